[rtl/core/gcr62_pkg.sv]
package gcr62_pkg;

    localparam logic [7:0] SECTOR_COUNT = 8'd16;

    localparam logic [7:0] PRO_FIRST   = 8'hD5;
    localparam logic [7:0] PRO_SECOND  = 8'hAA;
    localparam logic [7:0] PRO_ADDR    = 8'h96;
    localparam logic [7:0] PRO_DATA    = 8'hAD;
    localparam logic [7:0] ODD_MASK    = 8'hAA;
    localparam logic [7:0] EVEN_MASK   = 8'h55;

    localparam int LOW_COUNT  = 86;
    localparam int ADDR_LEN   = 8;
    localparam int SKIP_LEN   = 3;
    localparam int HIGH_COUNT = 256;

    localparam int SLOT_W = $clog2(LOW_COUNT);
    localparam int POS_W  = $clog2(HIGH_COUNT);

    localparam logic [POS_W-1:0] POS_PENDING = POS_W'(4);
    localparam logic [POS_W-1:0] POS_SECTOR  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_ADDR_END = POS_W'(ADDR_LEN - 1);
    localparam logic [POS_W-1:0] POS_SKIP_END = POS_W'(SKIP_LEN - 1);
    localparam logic [POS_W-1:0] POS_LOW_END  = POS_W'(LOW_COUNT - 1);
    localparam logic [POS_W-1:0] POS_HIGH_END = POS_W'(HIGH_COUNT - 1);

    localparam logic [1:0] KIND_ADDR = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_GOOD = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_SKIP  = 3'd2,
        PH_LOW   = 3'd3,
        PH_HIGH  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] nibble;
        logic       code_ok;
        logic [5:0] code_val;
    } nib_item_t;

    function automatic logic [6:0] gcr_decode(input logic [7:0] nib);
        logic [6:0] r;
        r = 7'd0;
        unique case (nib)
            8'h96: r = {1'b1, 6'd0};
            8'h97: r = {1'b1, 6'd1};
            8'h9A: r = {1'b1, 6'd2};
            8'h9B: r = {1'b1, 6'd3};
            8'h9D: r = {1'b1, 6'd4};
            8'h9E: r = {1'b1, 6'd5};
            8'h9F: r = {1'b1, 6'd6};
            8'hA6: r = {1'b1, 6'd7};
            8'hA7: r = {1'b1, 6'd8};
            8'hAB: r = {1'b1, 6'd9};
            8'hAC: r = {1'b1, 6'd10};
            8'hAD: r = {1'b1, 6'd11};
            8'hAE: r = {1'b1, 6'd12};
            8'hAF: r = {1'b1, 6'd13};
            8'hB2: r = {1'b1, 6'd14};
            8'hB3: r = {1'b1, 6'd15};
            8'hB4: r = {1'b1, 6'd16};
            8'hB5: r = {1'b1, 6'd17};
            8'hB6: r = {1'b1, 6'd18};
            8'hB7: r = {1'b1, 6'd19};
            8'hB9: r = {1'b1, 6'd20};
            8'hBA: r = {1'b1, 6'd21};
            8'hBB: r = {1'b1, 6'd22};
            8'hBC: r = {1'b1, 6'd23};
            8'hBD: r = {1'b1, 6'd24};
            8'hBE: r = {1'b1, 6'd25};
            8'hBF: r = {1'b1, 6'd26};
            8'hCB: r = {1'b1, 6'd27};
            8'hCD: r = {1'b1, 6'd28};
            8'hCE: r = {1'b1, 6'd29};
            8'hCF: r = {1'b1, 6'd30};
            8'hD3: r = {1'b1, 6'd31};
            8'hD6: r = {1'b1, 6'd32};
            8'hD7: r = {1'b1, 6'd33};
            8'hD9: r = {1'b1, 6'd34};
            8'hDA: r = {1'b1, 6'd35};
            8'hDB: r = {1'b1, 6'd36};
            8'hDC: r = {1'b1, 6'd37};
            8'hDD: r = {1'b1, 6'd38};
            8'hDE: r = {1'b1, 6'd39};
            8'hDF: r = {1'b1, 6'd40};
            8'hE5: r = {1'b1, 6'd41};
            8'hE6: r = {1'b1, 6'd42};
            8'hE7: r = {1'b1, 6'd43};
            8'hE9: r = {1'b1, 6'd44};
            8'hEA: r = {1'b1, 6'd45};
            8'hEB: r = {1'b1, 6'd46};
            8'hEC: r = {1'b1, 6'd47};
            8'hED: r = {1'b1, 6'd48};
            8'hEE: r = {1'b1, 6'd49};
            8'hEF: r = {1'b1, 6'd50};
            8'hF2: r = {1'b1, 6'd51};
            8'hF3: r = {1'b1, 6'd52};
            8'hF4: r = {1'b1, 6'd53};
            8'hF5: r = {1'b1, 6'd54};
            8'hF6: r = {1'b1, 6'd55};
            8'hF7: r = {1'b1, 6'd56};
            8'hF9: r = {1'b1, 6'd57};
            8'hFA: r = {1'b1, 6'd58};
            8'hFB: r = {1'b1, 6'd59};
            8'hFC: r = {1'b1, 6'd60};
            8'hFD: r = {1'b1, 6'd61};
            8'hFE: r = {1'b1, 6'd62};
            8'hFF: r = {1'b1, 6'd63};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] store_slot(input logic [POS_W-1:0] idx);
        logic [SLOT_W-1:0] s;
        if (idx < POS_W'(LOW_COUNT)) begin
            s = SLOT_W'(idx);
        end else if (idx < POS_W'(2 * LOW_COUNT)) begin
            s = SLOT_W'(idx - POS_W'(LOW_COUNT));
        end else begin
            s = SLOT_W'(idx - POS_W'(2 * LOW_COUNT));
        end
        return s;
    endfunction

    function automatic logic [1:0] store_pair(input logic [POS_W-1:0] idx,
                                              input logic [5:0] entry);
        logic [1:0] p;
        if (idx < POS_W'(LOW_COUNT)) begin
            p = entry[1:0];
        end else if (idx < POS_W'(2 * LOW_COUNT)) begin
            p = entry[3:2];
        end else begin
            p = entry[5:4];
        end
        return {p[0], p[1]};
    endfunction

endpackage

[rtl/core/gcr_6and2_sector_decoder_unit.sv]
// channel   | ports                                   | direction
// request   | s_valid, s_ready, s_disk_nibble         | in
// result    | m_valid, m_ready, m_result_kind,        | out
//           | m_sector_number, m_byte_index, m_data_value
//
// One nibble a cycle while no result stalls; each result passes the input register
// (with code lookup), then the field decoder and result register. The 86-entry low-bit
// store is read one nibble ahead, so its read port sets no limit. Reset is synchronous
// and active low; the store keeps its contents. A stalled result holds the result
// register and a full input register; s_ready stays high whenever m_ready is high.
module gcr_6and2_sector_decoder_unit
    import gcr62_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_disk_nibble,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_result_kind,
    output logic [7:0] m_sector_number,
    output logic [7:0] m_byte_index,
    output logic [7:0] m_data_value
);

    logic      item_valid;
    nib_item_t item;
    logic      item_take;

    gcr62_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_disk_nibble (s_disk_nibble),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    gcr62_field_decoder u_field_decoder (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item            (item),
        .item_take       (item_take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_sector_number (m_sector_number),
        .m_byte_index    (m_byte_index),
        .m_data_value    (m_data_value)
    );

endmodule

[rtl/core/gcr62_in_stage.sv]
module gcr62_in_stage
    import gcr62_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_disk_nibble,
    output logic       item_valid,
    output nib_item_t  item,
    input  logic       item_take
);

    logic      valid_reg;
    nib_item_t item_reg;
    logic [6:0] code;

    assign code    = gcr_decode(s_disk_nibble);
    assign s_ready = !valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{nibble: s_disk_nibble, code_ok: code[6], code_val: code[5:0]};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/core/gcr62_field_decoder.sv]
module gcr62_field_decoder
    import gcr62_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  nib_item_t  item,
    output logic       item_take,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_result_kind,
    output logic [7:0] m_sector_number,
    output logic [7:0] m_byte_index,
    output logic [7:0] m_data_value
);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]        recent_reg, recent_next;
    logic [7:0]         pending_reg, pending_next;
    logic [7:0]         sector_reg, sector_next;
    logic               known_reg, known_next;
    logic [5:0]         xor_reg, xor_next;
    logic               failed_reg, failed_next;

    logic [5:0]         store [LOW_COUNT];
    logic [5:0]         rd_data_reg;
    logic               wr_en;

    logic               emit;
    logic [1:0]         kind;
    logic [7:0]         res_index;
    logic [7:0]         res_data;
    logic [7:0]         res_sector;

    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic [7:0]         sector_out_reg;
    logic [7:0]         index_reg;
    logic [7:0]         data_reg;

    logic               prologue_seen;
    logic [5:0]         xor_mixed;
    logic [7:0]         addr_sector;

    assign item_take     = item_valid && (!out_valid_reg || m_ready);
    assign prologue_seen = (recent_reg == {PRO_FIRST, PRO_SECOND});
    assign xor_mixed     = xor_reg ^ item.code_val;
    assign addr_sector   = ({pending_reg[6:0], 1'b0} & ODD_MASK) | (item.nibble & EVEN_MASK);

    always_comb begin
        phase_next = phase_reg;
        if (item_take) begin
            unique case (phase_reg)
                PH_ADDR:  if (pos_reg == POS_ADDR_END) phase_next = PH_SKIP;
                PH_SKIP:  if (pos_reg == POS_SKIP_END) phase_next = PH_HUNT;
                PH_LOW:   if (pos_reg == POS_LOW_END) phase_next = PH_HIGH;
                PH_HIGH:  if (pos_reg == POS_HIGH_END) phase_next = PH_CHECK;
                PH_CHECK: phase_next = PH_SKIP;
                default: begin
                    phase_next = PH_HUNT;
                    if (prologue_seen && item.nibble == PRO_ADDR) begin
                        phase_next = PH_ADDR;
                    end else if (prologue_seen && item.nibble == PRO_DATA && known_reg
                                 && sector_reg < SECTOR_COUNT) begin
                        phase_next = PH_LOW;
                    end
                end
            endcase
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        recent_next  = recent_reg;
        pending_next = pending_reg;
        sector_next  = sector_reg;
        known_next   = known_reg;
        xor_next     = xor_reg;
        failed_next  = failed_reg;
        wr_en        = 1'b0;
        if (item_take) begin
            unique case (phase_reg)
                PH_ADDR: begin
                    if (pos_reg == POS_PENDING) pending_next = item.nibble;
                    if (pos_reg == POS_SECTOR) begin
                        sector_next = addr_sector;
                        known_next  = 1'b1;
                    end
                    pos_next = (pos_reg == POS_ADDR_END) ? '0 : pos_reg + 1'b1;
                end
                PH_SKIP: begin
                    if (pos_reg == POS_SKIP_END) begin
                        pos_next    = '0;
                        recent_next = '0;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                PH_LOW, PH_HIGH: begin
                    if (!item.code_ok) begin
                        failed_next = 1'b1;
                    end else if (!failed_reg) begin
                        xor_next = xor_mixed;
                        wr_en    = (phase_reg == PH_LOW);
                    end
                    if ((phase_reg == PH_LOW && pos_reg == POS_LOW_END)
                        || (phase_reg == PH_HIGH && pos_reg == POS_HIGH_END)) begin
                        pos_next = '0;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                PH_CHECK: begin
                    known_next = 1'b0;
                    pos_next   = '0;
                end
                default: begin
                    if (prologue_seen && item.nibble == PRO_ADDR) begin
                        pos_next    = '0;
                        recent_next = '0;
                    end else if (prologue_seen && item.nibble == PRO_DATA && known_reg
                                 && sector_reg < SECTOR_COUNT) begin
                        pos_next    = '0;
                        recent_next = '0;
                        xor_next    = '0;
                        failed_next = 1'b0;
                    end else begin
                        recent_next = {recent_reg[7:0], item.nibble};
                    end
                end
            endcase
        end
    end

    always_comb begin
        emit       = 1'b0;
        kind       = KIND_ADDR;
        res_index  = '0;
        res_data   = '0;
        res_sector = sector_reg;
        unique case (phase_reg)
            PH_ADDR: begin
                emit       = (pos_reg == POS_SECTOR);
                res_sector = addr_sector;
            end
            PH_HIGH: begin
                emit      = item.code_ok && !failed_reg;
                kind      = KIND_DATA;
                res_index = pos_reg;
                res_data  = {xor_mixed, store_pair(pos_reg, rd_data_reg)};
            end
            PH_CHECK: begin
                emit = 1'b1;
                kind = (failed_reg || !item.code_ok || xor_mixed != 6'd0) ? KIND_BAD
                                                                           : KIND_GOOD;
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            pos_reg     <= '0;
            recent_reg  <= '0;
            pending_reg <= '0;
            sector_reg  <= '0;
            known_reg   <= 1'b0;
            xor_reg     <= '0;
            failed_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            recent_reg  <= recent_next;
            pending_reg <= pending_next;
            sector_reg  <= sector_next;
            known_reg   <= known_next;
            xor_reg     <= xor_next;
            failed_reg  <= failed_next;
        end
    end

    // prefetch the entry for the next position so it is ready when the nibble arrives
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[SLOT_W'(pos_reg)] <= xor_mixed;
        end
        rd_data_reg <= store[store_slot(pos_next)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_take) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && emit) begin
            kind_reg       <= kind;
            sector_out_reg <= res_sector;
            index_reg      <= res_index;
            data_reg       <= res_data;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_sector_number = sector_out_reg;
    assign m_byte_index    = index_reg;
    assign m_data_value    = data_reg;

endmodule

[rtl/core/gcr62_checker.sv]
module gcr62_checker
    import gcr62_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_result_kind,
    input logic [7:0] m_sector_number,
    input logic [7:0] m_byte_index,
    input logic [7:0] m_data_value
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
        && $stable(m_sector_number) && $stable(m_byte_index) && $stable(m_data_value))
        else $error("stalled result changed");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while results drain");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != KIND_DATA |-> m_byte_index == 8'd0
        && m_data_value == 8'd0)
        else $error("non-data result carries index or data");

    a_input_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("request held while no result waits");

endmodule

bind gcr_6and2_sector_decoder_unit gcr62_checker u_gcr62_checker (.*);

[bench/gcr62_tb_pkg.sv]
package gcr62_tb_pkg;

    import gcr62_pkg::*;

    localparam bit [7:0] GCR_CODES [64] = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] sector;
        logic [7:0] index;
        logic [7:0] value;
    } sector_result_t;

    function automatic int code_value(input bit [7:0] nib);
        for (int i = 0; i < 64; i++) begin
            if (GCR_CODES[i] == nib) begin
                return i;
            end
        end
        return -1;
    endfunction

    class sector_decode_tracker;
        bit [15:0]      last_two = '0;
        phase_t         phase = PH_HUNT;
        int unsigned    pos = 0;
        bit [7:0]       odd_half = '0;
        bit [7:0]       sector = '0;
        bit             sector_valid = 1'b0;
        bit [5:0]       xsum = '0;
        bit [5:0]       low_store [LOW_COUNT];
        bit             failed = 1'b0;
        sector_result_t pending_results [$];
        int unsigned    errors = 0;
        int unsigned    requests = 0;
        int unsigned    addr_marks = 0;
        int unsigned    data_bytes = 0;
        int unsigned    good_fields = 0;
        int unsigned    bad_fields = 0;

        function void push(input logic [1:0] kind, input logic [7:0] idx,
                           input logic [7:0] val);
            sector_result_t r;
            r.kind   = kind;
            r.sector = sector;
            r.index  = idx;
            r.value  = val;
            pending_results.push_back(r);
        endfunction

        function void note_request(input bit [7:0] nib);
            int          v;
            int unsigned group;
            bit [7:0]    idx;
            bit [1:0]    pair;
            v = code_value(nib);
            requests++;
            case (phase)
                PH_ADDR: begin
                    if (pos == 4) begin
                        odd_half = nib;
                    end
                    pos++;
                    if (pos >= ADDR_LEN) begin
                        phase = PH_SKIP;
                        pos = 0;
                    end
                    if (pos == 6) begin
                        sector = ((odd_half << 1) & ODD_MASK) | (nib & EVEN_MASK);
                        sector_valid = 1'b1;
                        addr_marks++;
                        push(KIND_ADDR, 8'd0, 8'd0);
                    end
                end
                PH_SKIP: begin
                    pos++;
                    if (pos >= SKIP_LEN) begin
                        phase = PH_HUNT;
                        pos = 0;
                        last_two = '0;
                    end
                end
                PH_LOW: begin
                    if (v < 0) begin
                        failed = 1'b1;
                    end else if (!failed) begin
                        xsum ^= v[5:0];
                        low_store[pos] = xsum;
                    end
                    pos++;
                    if (pos >= LOW_COUNT) begin
                        phase = PH_HIGH;
                        pos = 0;
                    end
                end
                PH_HIGH: begin
                    idx = pos[7:0];
                    if (v < 0) begin
                        failed = 1'b1;
                    end else if (!failed) begin
                        xsum ^= v[5:0];
                        group = idx / LOW_COUNT;
                        pair = 2'(low_store[idx % LOW_COUNT] >> (2 * group));
                        push(KIND_DATA, idx, {xsum, pair[0], pair[1]});
                        data_bytes++;
                    end
                    pos++;
                    if (pos >= HIGH_COUNT) begin
                        phase = PH_CHECK;
                        pos = 0;
                    end
                end
                PH_CHECK: begin
                    if (failed || v < 0 || xsum != v[5:0]) begin
                        push(KIND_BAD, 8'd0, 8'd0);
                        bad_fields++;
                    end else begin
                        push(KIND_GOOD, 8'd0, 8'd0);
                        good_fields++;
                    end
                    sector_valid = 1'b0;
                    phase = PH_SKIP;
                    pos = 0;
                end
                default: begin
                    phase = PH_HUNT;
                    if (last_two == {PRO_FIRST, PRO_SECOND} && nib == PRO_ADDR) begin
                        phase = PH_ADDR;
                        pos = 0;
                        last_two = '0;
                    end else if (last_two == {PRO_FIRST, PRO_SECOND} && nib == PRO_DATA
                                 && sector_valid && sector < SECTOR_COUNT) begin
                        phase = PH_LOW;
                        pos = 0;
                        xsum = '0;
                        failed = 1'b0;
                        last_two = '0;
                    end else begin
                        last_two = {last_two[7:0], nib};
                    end
                end
            endcase
        endfunction

        function void check_result(input logic [1:0] kind, input logic [7:0] sec,
                                   input logic [7:0] idx, input logic [7:0] val);
            sector_result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d sector %0d index %0d value %0d",
                       kind, sec, idx, val);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind) begin
                $error("m_result_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (sec !== want.sector) begin
                $error("m_sector_number: expected %0d, got %0d", want.sector, sec);
                errors++;
            end
            if (idx !== want.index) begin
                $error("m_byte_index: expected %0d, got %0d", want.index, idx);
                errors++;
            end
            if (val !== want.value) begin
                $error("m_data_value: expected %0d, got %0d", want.value, val);
                errors++;
            end
        endfunction
    endclass

endpackage

[bench/gcr_6and2_sector_decoder_unit_tb.sv]
module gcr_6and2_sector_decoder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gcr62_pkg::*;
    import gcr62_tb_pkg::*;

    localparam bit [7:0] SYNC_NIBBLE = 8'hFF;
    localparam bit [7:0] EPI_FIRST   = 8'hDE;
    localparam bit [7:0] EPI_SECOND  = 8'hAA;
    localparam bit [7:0] EPI_THIRD   = 8'hEB;
    localparam bit [7:0] FIRST_SECTOR = 8'd3;
    localparam int unsigned RANDOM_ITEMS  = 500;
    localparam int unsigned MIN_FIELDS    = 2;
    localparam int unsigned HOLD_AT       = 150;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_disk_nibble = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_result_kind;
    logic [7:0] m_sector_number;
    logic [7:0] m_byte_index;
    logic [7:0] m_data_value;

    sector_decode_tracker sb = new;

    bit          sender_idle = 1'b1;
    bit          receiver_idle = 1'b1;
    int unsigned results_taken = 0;
    int unsigned cycle_count = 0;
    int unsigned data_fields = 0;

    gcr_6and2_sector_decoder_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_disk_nibble   (s_disk_nibble),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_sector_number (m_sector_number),
        .m_byte_index    (m_byte_index),
        .m_data_value    (m_data_value)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL gcr_6and2_sector_decoder_unit");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_result_kind, m_sector_number, m_byte_index, m_data_value);
        end
    end

    function automatic bit [7:0] bad_nibble();
        bit [7:0] nib;
        nib = 8'($urandom_range(0, 255));
        while (code_value(nib) >= 0) begin
            nib = 8'($urandom_range(0, 255));
        end
        return nib;
    endfunction

    task automatic send_nibble(input bit [7:0] nib);
        int unsigned gap;
        gap = sender_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_disk_nibble <= nib;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(nib);
    endtask

    task automatic send_prologue(input bit [7:0] third);
        send_nibble(PRO_FIRST);
        send_nibble(PRO_SECOND);
        send_nibble(third);
    endtask

    task automatic send_epilogue();
        if ($urandom_range(0, 5) == 0) begin
            repeat (SKIP_LEN) send_nibble(8'($urandom_range(0, 255)));
        end else begin
            send_nibble(EPI_FIRST);
            send_nibble(EPI_SECOND);
            send_nibble(EPI_THIRD);
        end
    endtask

    task automatic send_address(input bit [7:0] sec_byte, input bit raw);
        bit [7:0] pairs [4];
        pairs[0] = 8'($urandom_range(0, 255));
        pairs[1] = 8'($urandom_range(0, 255));
        pairs[2] = sec_byte;
        pairs[3] = pairs[0] ^ pairs[1] ^ sec_byte;
        send_prologue(PRO_ADDR);
        if (raw) begin
            repeat (ADDR_LEN) send_nibble(8'($urandom_range(0, 255)));
        end else begin
            foreach (pairs[i]) begin
                send_nibble((pairs[i] >> 1) | ODD_MASK);
                send_nibble(pairs[i] | ODD_MASK);
            end
        end
        send_epilogue();
    endtask

    // variant: 0 good, 1 bad checksum, 2 broken in high part, 3 broken in low part
    task automatic send_data_field(input int unsigned variant);
        bit [5:0]    sum;
        bit [5:0]    v;
        int unsigned bad_at;
        sum = '0;
        bad_at = (variant == 3) ? $urandom_range(0, LOW_COUNT - 1)
               : (variant == 2) ? LOW_COUNT + $urandom_range(0, HIGH_COUNT - 1) : 9999;
        repeat ($urandom_range(1, 5)) send_nibble(SYNC_NIBBLE);
        send_prologue(PRO_DATA);
        for (int i = 0; i < LOW_COUNT + HIGH_COUNT; i++) begin
            v = 6'($urandom_range(0, 63));
            sum ^= v;
            send_nibble((i == bad_at) ? bad_nibble() : GCR_CODES[v]);
        end
        if (variant != 1) begin
            send_nibble(GCR_CODES[sum]);
        end else if ($urandom_range(0, 1) == 0) begin
            send_nibble(bad_nibble());
        end else begin
            send_nibble(GCR_CODES[sum ^ 6'($urandom_range(1, 63))]);
        end
        send_epilogue();
    endtask

    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = receiver_idle ? $urandom_range(0, 19) : 0;
            if (results_taken == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
            if ($urandom_range(0, 39) == 0) begin
                receiver_idle = !receiver_idle;
            end
        end
    end

    initial begin
        int unsigned random_start;
        bit [7:0]    sec;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_nibble(8'h00);
        send_nibble(8'hFF);
        send_prologue(PRO_DATA);
        send_address(8'hFF, 1'b0);
        send_prologue(PRO_DATA);

        send_address(FIRST_SECTOR, 1'b0);
        send_data_field(data_fields % 4);
        data_fields++;

        random_start = sb.requests;
        while (sb.requests - random_start < RANDOM_ITEMS || data_fields < MIN_FIELDS) begin
            sender_idle = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0, 1: begin
                    if ($urandom_range(0, 2) == 0) begin
                        send_nibble(PRO_FIRST);
                        send_nibble(PRO_SECOND);
                    end
                    repeat ($urandom_range(1, 8)) send_nibble(8'($urandom_range(0, 255)));
                end
                default: begin
                    sec = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                        : 8'($urandom_range(0, SECTOR_COUNT - 1));
                    send_address(sec, $urandom_range(0, 7) == 0);
                    if ($urandom_range(0, 2) != 0) begin
                        send_data_field(data_fields % 4);
                        data_fields++;
                    end
                end
            endcase
        end
        s_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d nibbles, %0d data fields sent, %0d results taken",
                 sb.requests, data_fields, results_taken);
        $display("seen: %0d address marks, %0d data bytes, %0d good and %0d bad fields",
                 sb.addr_marks, sb.data_bytes, sb.good_fields, sb.bad_fields);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("PASS gcr_6and2_sector_decoder_unit");
        end else begin
            $display("FAIL gcr_6and2_sector_decoder_unit");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/gcr62_pkg.sv
rtl/core/gcr62_in_stage.sv
rtl/core/gcr62_field_decoder.sv
rtl/core/gcr_6and2_sector_decoder_unit.sv
rtl/core/gcr62_checker.sv
bench/gcr62_tb_pkg.sv
bench/gcr_6and2_sector_decoder_unit_tb.sv
